### hw/rtl/sas_pkg.sv
// Shared types and constants for the signed array sorter.
// Used by sas_cell and signed_array_sorter; depends on nothing.
`timescale 1ns / 1ps

package sas_pkg;

    localparam int VAL_W     = 16;
    localparam int DEPTH_DEF = 64;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        t_val value;
        logic last;
    } t_in_word;

    typedef struct packed {
        t_val value_res;
        logic last_res;
        logic overflow;
    } t_out_word;

    // Broadcast control for the cell chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

### hw/rtl/sas_cell.sv
// One cell of the insertion sorting chain: holds one element of the sorted row.
// Depends on sas_pkg for the element and control types.
`timescale 1ns / 1ps

module sas_cell (
    input  logic                i_clk,
    input  sas_pkg::t_cell_ctrl i_ctrl,
    input  sas_pkg::t_val       i_new_val,
    input  logic                i_occupied,
    input  logic                i_prev_take,
    input  sas_pkg::t_val       i_prev_val,
    input  sas_pkg::t_val       i_next_val,
    output logic                o_take,
    output sas_pkg::t_val       o_val
);

    sas_pkg::t_val r_val;
    sas_pkg::t_val n_val;

    // An empty cell counts as holding plus infinity, so it always takes.
    assign o_take = !i_occupied || (i_new_val < r_val);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert) begin
            if (o_take) begin
                // If the cell below also moves up, its old element slides here;
                // otherwise this is the insertion point for the new element.
                n_val = i_prev_take ? i_prev_val : i_new_val;
            end
        end else if (i_ctrl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### hw/rtl/signed_array_sorter.sv
// Top level of the signed array sorter: control, element count and the cell chain.
// Depends on sas_pkg and sas_cell.
`timescale 1ns / 1ps

// Usage.
// Input words are offered on i_in with start; a word is taken at a rising edge
// where start is high and busy is low. While loading, one word is taken every
// cycle with start high and slotted into its sorted place in a chain of DEPTH
// cells, each of which compares the new element against its own and shifts by
// one place. Words beyond DEPTH are dropped and the run is marked overflowed.
// The word with last set ends the set. From the next cycle busy is high and
// the stored elements come out of the head of the chain in ascending order,
// one result per cycle on o_res with o_res_valid high for one cycle each;
// the chain shifts towards its head once per result. busy falls with the cycle
// after the final result (last_res set), so the next set may start then. The
// receiver cannot stall: every strobed result is taken in its cycle. A
// synchronous low i_rst_n empties the store, clears the overflow mark and
// returns the block to loading.

module signed_array_sorter #(
    parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sas_pkg::t_in_word  i_in,
    output logic               o_res_valid,
    output sas_pkg::t_out_word o_res
);

    localparam int COUNT_W = $clog2(DEPTH + 1);

    sas_pkg::t_state     r_state;
    sas_pkg::t_state     n_state;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic                r_dropped;
    logic                n_dropped;

    logic                accept;
    logic                full;
    sas_pkg::t_cell_ctrl ctrl;

    logic                take [DEPTH];
    sas_pkg::t_val       cval [DEPTH];

    assign accept = start && !busy;
    assign full   = (r_count == COUNT_W'(DEPTH));

    always_comb begin
        ctrl.insert = accept && !full;
        ctrl.shift  = (r_state == sas_pkg::ST_EMIT);
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        sas_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new_val   (i_in.value),
            .i_occupied  (COUNT_W'(gi) < r_count),
            .i_prev_take ((gi == 0) ? 1'b0 : take[(gi == 0) ? 0 : gi - 1]),
            .i_prev_val  ((gi == 0) ? sas_pkg::t_val'(0) : cval[(gi == 0) ? 0 : gi - 1]),
            .i_next_val  ((gi == DEPTH - 1) ? sas_pkg::t_val'(0)
                                            : cval[(gi == DEPTH - 1) ? gi : gi + 1]),
            .o_take      (take[gi]),
            .o_val       (cval[gi])
        );
    end

    // Next state, count and overflow mark.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        case (r_state)
            sas_pkg::ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (i_in.last) begin
                        n_state = sas_pkg::ST_EMIT;
                    end
                end
            end
            sas_pkg::ST_EMIT: begin
                n_count = r_count - COUNT_W'(1);
                if (r_count == COUNT_W'(1)) begin
                    n_state   = sas_pkg::ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = sas_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        busy            = 1'b0;
        o_res_valid     = 1'b0;
        o_res.value_res = cval[0];
        o_res.last_res  = (r_count == COUNT_W'(1));
        o_res.overflow  = r_dropped;
        case (r_state)
            sas_pkg::ST_LOAD: begin
                busy        = 1'b0;
                o_res_valid = 1'b0;
            end
            sas_pkg::ST_EMIT: begin
                busy        = 1'b1;
                o_res_valid = 1'b1;
            end
            default: begin
                busy        = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sas_pkg::ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("element count exceeds store depth");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_res |=>
            o_res_valid && (o_res.value_res >= $past(o_res.value_res)))
        else $error("results not in ascending order");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_res |=> !busy && (r_count == '0) && !r_dropped)
        else $error("run did not end cleanly after the final result");

    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_res |=> o_res.overflow == $past(o_res.overflow))
        else $error("overflow mark changed within a run");
`endif

endmodule

### verif/sas_checker.sv
// Checker for the signed array sorter: watches the input and result channels,
// predicts each sorted run and compares every result word field by field.
// Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_checker #(
    parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  sas_pkg::t_in_word  i_in,
    input  logic               i_res_valid,
    input  sas_pkg::t_out_word i_res,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    import sas_pkg::*;

    localparam int MAX_PRINTED = 100;

    // Elements of the set being loaded, kept in ascending order as they arrive.
    t_val      held_elems[$];
    logic      set_overflowed;
    // Result words still owed by the block, oldest first.
    t_out_word sorted_run_q[$];
    int        mismatch_cnt;

    initial begin
        o_fail_cnt   = 0;
        o_pending    = 0;
        mismatch_cnt = 0;
        set_overflowed = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTED) begin
            $display("[%0t] sorter mismatch: %s", $time, what);
        end
        mismatch_cnt++;
    endtask

    // Files one element into the held set and, on the word that ends the set,
    // queues the whole run in ascending order.
    task automatic file_element(input t_in_word word);
        int        idx;
        t_val      tmp;
        t_out_word run_word;
        if (held_elems.size() < DEPTH) begin
            held_elems.push_back(word.value);
            idx = held_elems.size() - 1;
            while (idx > 0 && held_elems[idx-1] > held_elems[idx]) begin
                tmp                 = held_elems[idx];
                held_elems[idx]     = held_elems[idx-1];
                held_elems[idx-1]   = tmp;
                idx--;
            end
        end else begin
            set_overflowed = 1'b1;
        end
        if (word.last) begin
            for (idx = 0; idx < held_elems.size(); idx++) begin
                run_word.value_res = held_elems[idx];
                run_word.last_res  = (idx == held_elems.size() - 1);
                run_word.overflow  = set_overflowed;
                sorted_run_q.push_back(run_word);
            end
            held_elems.delete();
            set_overflowed = 1'b0;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (sorted_run_q.size() == 0) begin
            report_mismatch($sformatf("result word %0d with nothing expected",
                                      got.value_res));
        end else begin
            want = sorted_run_q.pop_front();
            if (got.value_res !== want.value_res) begin
                report_mismatch($sformatf("value_res %0d, expected %0d",
                                          got.value_res, want.value_res));
            end
            if (got.last_res !== want.last_res) begin
                report_mismatch($sformatf("last_res %b, expected %b on value %0d",
                                          got.last_res, want.last_res, want.value_res));
            end
            if (got.overflow !== want.overflow) begin
                report_mismatch($sformatf("overflow %b, expected %b on value %0d",
                                          got.overflow, want.overflow, want.value_res));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_elems.delete();
            sorted_run_q.delete();
            set_overflowed = 1'b0;
        end else begin
            // A result seen at this edge can only belong to an earlier set,
            // so it is checked before the incoming word is filed.
            if (i_res_valid) begin
                check_result(i_res);
            end
            if (i_start && !i_busy) begin
                file_element(i_in);
            end
        end
        o_pending  <= sorted_run_q.size();
        o_fail_cnt <= mismatch_cnt;
    end

endmodule

### verif/tb_top.sv
// Top of the signed array sorter testbench: clock, reset, stimulus and verdict.
// Depends on sas_pkg, signed_array_sorter and sas_checker.
`timescale 1ns / 1ps

module tb_top;
    import sas_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_PCT   = 37;
    localparam int RAND_ITEMS = 260;
    localparam int STALL_MAX  = 1000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in;
    logic      o_res_valid;
    t_out_word o_res;
    int        fail_cnt;
    int        pending;
    int        stall_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_array_sorter #(.DEPTH(DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    sas_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_res_valid (o_res_valid),
        .i_res       (o_res),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    // Ends the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((start && !busy) || o_res_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_val pick_value();
        case ($urandom_range(0, 9))
            0:       return t_val'(16'sh8000);
            1:       return t_val'(16'sh7fff);
            2:       return t_val'(0);
            3, 4:    return t_val'(int'($urandom_range(0, 8)) - 4);
            default: return t_val'($urandom);
        endcase
    endfunction

    // Offers one word and returns at the edge where the block takes it.
    task automatic send_word(input t_val value, input logic last, input int idle_pct);
        t_in_word word;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_in  <= t_in_word'($urandom);
            @(posedge i_clk);
        end
        word.value = value;
        word.last  = last;
        start <= 1'b1;
        i_in  <= word;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic send_random_set(input int n_words, input int idle_pct);
        int k;
        for (k = 0; k < n_words; k++) begin
            send_word(pick_value(), k == n_words - 1, idle_pct);
        end
    endtask

    // Holds the sender off until every predicted result word has come back.
    task automatic drain_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // Directed sets: lone extremes, duplicates, both extremes together with zero and
    // its neighbours, a descending set and an ascending set.
    t_val directed_vals[20] = '{
        16'sh7fff,
        16'sh8000,
        16'sd5, 16'sd5, 16'sd5,
        16'sd0, -16'sd1, 16'sd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
        16'sd40, 16'sd30, 16'sd20, -16'sd10,
        -16'sd300, -16'sd2, 16'sd7, 16'sd900
    };
    bit directed_last[20] = '{
        1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1
    };

    initial begin
        int sent;
        int set_idx;
        int n_words;
        int idle_pct;
        int k;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < 20; k++) begin
            send_word(directed_vals[k], directed_last[k], IDLE_PCT);
        end
        drain_results();

        // Store boundary: exactly full, a dropped word that ends the set,
        // and several dropped words before the end.
        send_random_set(DEPTH, IDLE_PCT);
        send_random_set(DEPTH + 1, IDLE_PCT);
        send_random_set(DEPTH + 5, 0);
        drain_results();

        sent    = 0;
        set_idx = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       n_words = DEPTH + $urandom_range(0, 4);
                1:       n_words = DEPTH - $urandom_range(0, 2);
                2:       n_words = $urandom_range(13, DEPTH - 3);
                default: n_words = $urandom_range(1, 12);
            endcase
            // Sets ten to twenty run without any idling on the sender side.
            idle_pct = (set_idx >= 10 && set_idx <= 20) ? 0 : IDLE_PCT;
            send_random_set(n_words, idle_pct);
            sent += n_words;
            set_idx++;
            if (set_idx % 5 == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (DEPTH + 10) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
